/* rtl/dots_pkg.sv */
package dots_pkg;

  localparam int AGENT_W = 8;
  localparam int DELAY_W = 16;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 7;

  localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESCHEDULE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP        = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [AGENT_W-1:0] agent;
    logic [DELAY_W-1:0] delay;
  } cmd_word_t;

  typedef struct packed {
    logic [AGENT_W-1:0] due_agent;
    logic [DELAY_W-1:0] elapsed;
    logic [STAT_W-1:0]  status;
    logic [OCC_W-1:0]   occupancy;
  } res_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              append;
    logic              match;
    logic              find;
    logic              compare;
    logic              insert;
    logic              pop_sel;
    logic              pop_sub;
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              emit;
  } dp_ctl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             found;
    logic             full;
    logic             empty;
  } dp_stat_t;

endpackage

/* rtl/dots_prefix_or.sv */
module dots_prefix_or #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] vec,
  output logic [WIDTH-1:0] incl
);

  localparam int LEVELS = $clog2(WIDTH);

  logic [WIDTH-1:0] lvl [0:LEVELS];

  // Log-depth scan: bit i of the result is set when any bit at or below i is set.
  assign lvl[0] = vec;

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    assign lvl[k+1] = lvl[k] | (lvl[k] << (1 << k));
  end

  assign incl = lvl[LEVELS];

endmodule

/* rtl/dots_datapath.sv */
module dots_datapath import dots_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_word_t cmd_word,
  input  dp_ctl_t   ctl,
  output dp_stat_t  stat,
  output res_word_t res_word
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [AGENT_W-1:0] cell_agent [MAX_ENTRIES];
  logic [DELAY_W-1:0] cell_delay [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] flags;
  logic [CW-1:0]      count;
  cmd_word_t          op;
  logic [DELAY_W-1:0] t_q;
  logic [AGENT_W-1:0] res_due;
  logic [DELAY_W-1:0] res_elapsed;
  logic [STAT_W-1:0]  res_status;
  res_word_t          res_q;

  logic [MAX_ENTRIES-1:0] valid;
  logic [MAX_ENTRIES-1:0] at_count;
  logic [MAX_ENTRIES-1:0] last_sel;
  logic [MAX_ENTRIES-1:0] incl;
  logic [MAX_ENTRIES-1:0] first;
  logic [MAX_ENTRIES-1:0] pick;
  logic [AGENT_W-1:0]     pick_agent;
  logic [DELAY_W-1:0]     pick_delay;
  logic [DELAY_W:0]       sum;
  logic [DELAY_W-1:0]     t_new;
  logic [31:0]            count_ext;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid[i]    = CW'(i) < count;
      at_count[i] = CW'(i) == count;
      last_sel[i] = CW'(i + 1) == count;
    end
  end

  dots_prefix_or #(.WIDTH(MAX_ENTRIES)) u_prefix (
    .vec  (flags),
    .incl (incl)
  );

  // First flagged cell, counted from position 0.
  assign first = flags & ~{incl[MAX_ENTRIES-2:0], 1'b0};
  assign pick  = ctl.pop_sel ? last_sel : first;

  always_comb begin
    pick_agent = '0;
    pick_delay = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      pick_agent = pick_agent | (cell_agent[i] & {AGENT_W{pick[i]}});
      pick_delay = pick_delay | (cell_delay[i] & {DELAY_W{pick[i]}});
    end
  end

  assign sum   = {1'b0, op.delay} + {1'b0, pick_delay};
  assign t_new = sum[DELAY_W] ? {DELAY_W{1'b1}} : sum[DELAY_W-1:0];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ctl.append && at_count[g]) begin
        cell_agent[g] <= op.agent;
        cell_delay[g] <= '0;
      end else if (ctl.insert && first[g]) begin
        cell_agent[g] <= op.agent;
        cell_delay[g] <= t_q;
      end else if (ctl.pop_sub) begin
        cell_delay[g] <= (cell_delay[g] >= res_elapsed) ? cell_delay[g] - res_elapsed : '0;
      end else begin
        if (g < MAX_ENTRIES - 1) begin
          if (ctl.find && incl[g]) begin
            cell_agent[g] <= cell_agent[(g + 1) % MAX_ENTRIES];
            cell_delay[g] <= cell_delay[(g + 1) % MAX_ENTRIES];
          end
        end
        if (g > 0) begin
          if (ctl.insert && incl[g]) begin
            cell_agent[g] <= cell_agent[(g + MAX_ENTRIES - 1) % MAX_ENTRIES];
            cell_delay[g] <= cell_delay[(g + MAX_ENTRIES - 1) % MAX_ENTRIES];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.match) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        flags[i] <= valid[i] && (cell_agent[i] == op.agent);
      end
    end else if (ctl.compare) begin
      // Empty positions count as smaller, so the word lands at the tail when nothing is.
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        flags[i] <= !valid[i] || (cell_delay[i] <= t_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.append || ctl.insert) begin
      count <= count + CW'(1);
    end else if (ctl.find && stat.found) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op <= cmd_word;
    end
    if (ctl.find) begin
      t_q <= stat.found ? t_new : op.delay;
    end
    if (ctl.load) begin
      res_due     <= '0;
      res_elapsed <= '0;
      res_status  <= ST_OK;
    end else begin
      if (ctl.set_status) begin
        res_status <= ctl.status;
      end
      if (ctl.pop_sel) begin
        res_due     <= pick_agent;
        res_elapsed <= pick_delay;
      end
    end
    if (ctl.emit) begin
      res_q.due_agent <= res_due;
      res_q.elapsed   <= res_elapsed;
      res_q.status    <= res_status;
      res_q.occupancy <= count_ext[OCC_W-1:0];
    end
  end

  assign count_ext  = 32'(count);
  assign stat.cmd   = op.cmd;
  assign stat.found = incl[MAX_ENTRIES-1];
  assign stat.full  = count == CW'(MAX_ENTRIES);
  assign stat.empty = count == '0;
  assign res_word   = res_q;

endmodule

/* rtl/dots_ctrl.sv */
module dots_ctrl import dots_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  logic [CMD_W-1:0] cmd_code,
  output logic             cmd_ready,
  output logic             res_valid,
  input  logic             res_ready,
  input  dp_stat_t         stat,
  output dp_ctl_t          ctl
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_APP   = 4'd1;
  localparam logic [3:0] S_MATCH = 4'd2;
  localparam logic [3:0] S_FIND  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_INS   = 4'd5;
  localparam logic [3:0] S_PSEL  = 4'd6;
  localparam logic [3:0] S_PSUB  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       res_valid_next;

  assign cmd_ready = state == S_IDLE;

  always_comb begin
    state_next     = state;
    ctl            = '0;
    ctl.status     = ST_OK;
    res_valid_next = res_valid && !res_ready;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load = 1'b1;
          unique case (cmd_code) inside
            CMD_REGISTER:                state_next = S_APP;
            CMD_REMOVE, CMD_RESCHEDULE:  state_next = S_MATCH;
            CMD_POP:                     state_next = S_PSEL;
            default:                     state_next = S_IDLE;
          endcase
        end
      end
      S_APP: begin
        if (stat.full) begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_FULL;
        end else begin
          ctl.append = 1'b1;
        end
        state_next = S_DONE;
      end
      S_MATCH: begin
        ctl.match  = 1'b1;
        state_next = S_FIND;
      end
      S_FIND: begin
        ctl.find = 1'b1;
        if (stat.cmd == CMD_REMOVE) begin
          if (!stat.found) begin
            ctl.set_status = 1'b1;
            ctl.status     = ST_ABSENT;
          end
          state_next = S_DONE;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.full) begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_FULL;
          state_next     = S_DONE;
        end else begin
          ctl.compare = 1'b1;
          state_next  = S_INS;
        end
      end
      S_INS: begin
        ctl.insert = 1'b1;
        state_next = S_DONE;
      end
      S_PSEL: begin
        if (stat.empty) begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_EMPTY;
          state_next     = S_DONE;
        end else begin
          ctl.pop_sel = 1'b1;
          state_next  = S_PSUB;
        end
      end
      S_PSUB: begin
        ctl.pop_sub = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        // The result register is refilled once its previous word has gone.
        if (!res_valid || res_ready) begin
          ctl.emit       = 1'b1;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

/* rtl/delay_ordered_turn_scheduler_top.sv */
// Channel  Handshake              Payload      Carries
// command  cmd_valid / cmd_ready  cmd_word     cmd, agent, delay
// result   res_valid / res_ready  res_word     due_agent, elapsed, status, occupancy
//
// One command is taken at a time. Register appends at the tail unless the table is full;
// remove matches the agent and shifts its entry out; reschedule does so too, then compares
// and inserts unless full; pop, when the table is not empty, selects the tail and subtracts
// its delay from every cell. The next command is taken in the cycle after the result loads.
// The result sits in an output register, so a new command is taken while it waits.
// A stalled result holds the controller in its last step until the word is taken.
// Synchronous reset empties the table and drops any pending result.
module delay_ordered_turn_scheduler_top import dots_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_word_t cmd_word,
  output logic      res_valid,
  input  logic      res_ready,
  output res_word_t res_word
);

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(MAX_ENTRIES);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  dots_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_code  (cmd_word.cmd),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  dots_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd_word (cmd_word),
    .ctl      (ctl),
    .stat     (stat),
    .res_word (res_word)
  );

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while another is in progress");

  a_empty_pop_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.status == ST_EMPTY |->
      res_word.due_agent == '0 && res_word.elapsed == '0 && res_word.occupancy == '0)
    else $error("empty pop reported an agent or a delay");

  a_full_occupancy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.status == ST_FULL |-> res_word.occupancy == FULL_OCC)
    else $error("dropped insert reported with a table that is not full");

  a_count_sane: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("table is both full and empty");
`endif

endmodule
